@@ rtl/core/m3inv_pkg.sv @@
// shared types, widths and constants of the 3x3 matrix inverse pipeline
package m3inv_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int NE            = 9;           // entries per matrix
    localparam int EW            = 32;          // entry width
    localparam int THR_W         = 31;          // threshold register width
    localparam int PW            = 2 * EW;      // entry product width
    localparam int CW            = PW + 1;      // signed cofactor width
    localparam int CAW           = PW;          // cofactor magnitude width
    localparam int DETW          = 99;          // signed determinant width
    localparam int MAGW          = 97;          // determinant magnitude width
    localparam int QBITS         = 33;          // quotient bits before saturation
    localparam int DET_STAGES    = 7;
    localparam int DIV_STAGES    = QBITS + 2;

    localparam logic [EW-1:0]  SAT_POS = 32'h7FFF_FFFF;
    localparam logic [EW-1:0]  SAT_NEG = 32'h8000_0000;
    localparam logic [QBITS:0] LIM_POS = {2'b00, SAT_POS};
    localparam logic [QBITS:0] LIM_NEG = {2'b00, SAT_NEG};

    // cofactor operand indexes: cof = a[k0]*a[k1] - a[k2]*a[k3]
    localparam int COF_IDX [NE][4] = '{
        '{4, 8, 7, 5}, '{7, 2, 1, 8}, '{1, 5, 4, 2},
        '{6, 5, 3, 8}, '{0, 8, 6, 2}, '{3, 2, 0, 5},
        '{3, 7, 6, 4}, '{6, 1, 0, 7}, '{0, 4, 3, 1}
    };

    typedef logic signed [EW-1:0] elem_t;

    typedef struct packed {
        logic [MAGW-1:0]         mag;
        logic                    det_neg;
        logic [NE-1:0]           cneg;
        logic [NE-1:0][CAW-1:0]  cabs;
    } det_res_t;

    typedef struct packed {
        logic                    sing;
        logic [NE-1:0]           neg;
        logic [NE-1:0]           ov;
        logic [NE-1:0][QBITS:0]  qr;
    } div_res_t;

endpackage

@@ rtl/core/m3inv_if.sv @@
// request channel interfaces for matrix input and inverse output
interface m3inv_in_if;
    import m3inv_pkg::*;
    logic  valid;
    logic  ready;
    elem_t col0_row0, col0_row1, col0_row2;
    elem_t col1_row0, col1_row1, col1_row2;
    elem_t col2_row0, col2_row1, col2_row2;

    modport source (output valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1,
                    col1_row2, col2_row0, col2_row1, col2_row2, input ready);
    modport sink   (input valid, col0_row0, col0_row1, col0_row2, col1_row0, col1_row1,
                    col1_row2, col2_row0, col2_row1, col2_row2, output ready);
endinterface

interface m3inv_out_if;
    import m3inv_pkg::*;
    logic  valid;
    logic  ready;
    logic  invertible;
    elem_t inv_col0_row0, inv_col0_row1, inv_col0_row2;
    elem_t inv_col1_row0, inv_col1_row1, inv_col1_row2;
    elem_t inv_col2_row0, inv_col2_row1, inv_col2_row2;

    modport source (output valid, invertible, inv_col0_row0, inv_col0_row1, inv_col0_row2,
                    inv_col1_row0, inv_col1_row1, inv_col1_row2, inv_col2_row0,
                    inv_col2_row1, inv_col2_row2, input ready);
    modport sink   (input valid, invertible, inv_col0_row0, inv_col0_row1, inv_col0_row2,
                    inv_col1_row0, inv_col1_row1, inv_col1_row2, inv_col2_row0,
                    inv_col2_row1, inv_col2_row2, output ready);
endinterface

@@ rtl/core/m3inv_det.sv @@
// cofactor and determinant pipeline
module m3inv_det
    import m3inv_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    m3inv_in_if.sink matrix,
    input  logic     dn_ready,
    output logic     dn_valid,
    output det_res_t dn_data
);

    localparam int NS = DET_STAGES;

    logic [NS:0]   en;
    logic [NS-1:0] v_reg, v_next;

    assign en[NS] = dn_ready;
    for (genvar s = 0; s < NS; s++)
    begin : g_en
        assign en[s] = !v_reg[s] || en[s+1];
    end
    assign matrix.ready = en[0];
    assign dn_valid     = v_reg[NS-1];

    always_comb
    begin
        v_next[0] = en[0] ? matrix.valid : v_reg[0];
        for (int s = 1; s < NS; s++)
        begin
            v_next[s] = en[s] ? v_reg[s-1] : v_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    elem_t                  a0_reg [NE];
    logic signed [PW-1:0]   p_reg [2*NE], p_next [2*NE];
    elem_t                  a1_reg [3], a2_reg [3];
    logic signed [CW-1:0]   cof_reg [NE], cof_next [NE];
    logic signed [CW-1:0]   pl_reg [3], pl_next [3], ph_reg [3], ph_next [3];
    logic [CAW-1:0]         cabs3_reg [NE], cabs3_next [NE];
    logic [CAW-1:0]         cabs4_reg [NE], cabs5_reg [NE], cabs6_reg [NE];
    logic [NE-1:0]          cneg3_reg, cneg4_reg, cneg5_reg, cneg6_reg, cneg3_next;
    logic signed [DETW-1:0] prod_reg [3], prod_next [3];
    logic signed [DETW-1:0] det_reg, det_next;
    logic [MAGW-1:0]        mag_reg, mag_next;
    logic                   dneg_reg;

    always_comb
    begin
        logic signed [CW-1:0] cneg_val;
        for (int i = 0; i < NE; i++)
        begin
            p_next[2*i]   = a0_reg[COF_IDX[i][0]] * a0_reg[COF_IDX[i][1]];
            p_next[2*i+1] = a0_reg[COF_IDX[i][2]] * a0_reg[COF_IDX[i][3]];
            cof_next[i]   = p_reg[2*i] - p_reg[2*i+1];
            cneg_val      = -cof_reg[i];
            cneg3_next[i] = cof_reg[i][CW-1];
            cabs3_next[i] = cof_reg[i][CW-1] ? cneg_val[CAW-1:0] : cof_reg[i][CAW-1:0];
        end
        // 32 x 65 product split into two 32 x 33 partial products
        for (int j = 0; j < 3; j++)
        begin
            pl_next[j]   = a2_reg[j] * $signed({1'b0, cof_reg[j][EW-1:0]});
            ph_next[j]   = a2_reg[j] * $signed(cof_reg[j][CW-1:EW]);
            prod_next[j] = $signed({ph_reg[j], {EW{1'b0}}}) + pl_reg[j];
        end
        det_next = prod_reg[0] + prod_reg[1] + prod_reg[2];
        mag_next = det_reg[DETW-1] ? MAGW'(-det_reg) : MAGW'(det_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a0_reg[0] <= matrix.col0_row0;
            a0_reg[1] <= matrix.col0_row1;
            a0_reg[2] <= matrix.col0_row2;
            a0_reg[3] <= matrix.col1_row0;
            a0_reg[4] <= matrix.col1_row1;
            a0_reg[5] <= matrix.col1_row2;
            a0_reg[6] <= matrix.col2_row0;
            a0_reg[7] <= matrix.col2_row1;
            a0_reg[8] <= matrix.col2_row2;
        end
        if (en[1])
        begin
            p_reg <= p_next;
            for (int j = 0; j < 3; j++)
            begin
                a1_reg[j] <= a0_reg[3*j];
            end
        end
        if (en[2])
        begin
            cof_reg <= cof_next;
            a2_reg  <= a1_reg;
        end
        if (en[3])
        begin
            pl_reg    <= pl_next;
            ph_reg    <= ph_next;
            cabs3_reg <= cabs3_next;
            cneg3_reg <= cneg3_next;
        end
        if (en[4])
        begin
            prod_reg  <= prod_next;
            cabs4_reg <= cabs3_reg;
            cneg4_reg <= cneg3_reg;
        end
        if (en[5])
        begin
            det_reg   <= det_next;
            cabs5_reg <= cabs4_reg;
            cneg5_reg <= cneg4_reg;
        end
        if (en[6])
        begin
            mag_reg   <= mag_next;
            dneg_reg  <= det_reg[DETW-1];
            cabs6_reg <= cabs5_reg;
            cneg6_reg <= cneg5_reg;
        end
    end

    always_comb
    begin
        dn_data.mag     = mag_reg;
        dn_data.det_neg = dneg_reg;
        dn_data.cneg    = cneg6_reg;
        for (int i = 0; i < NE; i++)
        begin
            dn_data.cabs[i] = cabs6_reg[i];
        end
    end

endmodule

@@ rtl/core/m3inv_div.sv @@
// nine-lane restoring divider, one quotient bit per stage, with rounding
module m3inv_div
    import m3inv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [THR_W-1:0] thr,
    input  logic             up_valid,
    output logic             up_ready,
    input  det_res_t         up_data,
    input  logic             dn_ready,
    output logic             dn_valid,
    output div_res_t         dn_data
);

    localparam int NS = DIV_STAGES;
    localparam int NW = CAW + 2 * FRAC_BITS;

    logic [NS:0]   en;
    logic [NS-1:0] v_reg, v_next;

    assign en[NS] = dn_ready;
    for (genvar s = 0; s < NS; s++)
    begin : g_en
        assign en[s] = !v_reg[s] || en[s+1];
    end
    assign up_ready = en[0];
    assign dn_valid = v_reg[NS-1];

    always_comb
    begin
        v_next[0] = en[0] ? up_valid : v_reg[0];
        for (int s = 1; s < NS; s++)
        begin
            v_next[s] = en[s] ? v_reg[s-1] : v_reg[s];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= v_next;
        end
    end

    logic [MAGW-1:0]  r_reg  [QBITS+1][NE];
    logic [QBITS-1:0] q_reg  [QBITS+1][NE];
    logic [QBITS-1:0] nl_reg [QBITS][NE];
    logic [MAGW-1:0]  d_reg  [QBITS+1];
    logic [NE-1:0]    ov_reg [NS];
    logic [NE-1:0]    neg_reg [NS];
    logic             sing_reg [NS];
    logic [QBITS:0]   qr_reg [NE];

    // stage 0: singular test, top remainder and overflow check
    logic [MAGW-1:0]  lim;
    logic [MAGW-1:0]  r0_next [NE];
    logic [QBITS-1:0] nl0_next [NE];
    logic [NE-1:0]    ov0_next;
    logic             sing0_next;

    always_comb
    begin
        logic [NW-1:0]   num;
        logic [MAGW-1:0] r0;
        lim        = MAGW'({thr, {(2*FRAC_BITS){1'b0}}});
        sing0_next = (up_data.mag == '0) || (up_data.mag < lim);
        for (int i = 0; i < NE; i++)
        begin
            num         = {up_data.cabs[i], {(2*FRAC_BITS){1'b0}}};
            r0          = MAGW'(num[NW-1:QBITS]);
            ov0_next[i] = (r0 >= up_data.mag);
            r0_next[i]  = ov0_next[i] ? '0 : r0;
            nl0_next[i] = num[QBITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            r_reg[0]    <= r0_next;
            nl_reg[0]   <= nl0_next;
            d_reg[0]    <= up_data.mag;
            ov_reg[0]   <= ov0_next;
            neg_reg[0]  <= up_data.cneg ^ {NE{up_data.det_neg}};
            sing_reg[0] <= sing0_next;
            for (int i = 0; i < NE; i++)
            begin
                q_reg[0][i] <= '0;
            end
        end
    end

    // stages 1..QBITS: one compare and subtract per lane
    for (genvar s = 1; s <= QBITS; s++)
    begin : g_step
        logic [MAGW-1:0]  r_next [NE];
        logic [QBITS-1:0] q_next [NE];
        logic [QBITS-1:0] nl_next [NE];

        always_comb
        begin
            logic [MAGW:0] rs;
            logic          ge;
            for (int i = 0; i < NE; i++)
            begin
                rs          = {r_reg[s-1][i], nl_reg[s-1][i][QBITS-1]};
                ge          = (rs >= {1'b0, d_reg[s-1]});
                r_next[i]   = ge ? MAGW'(rs - {1'b0, d_reg[s-1]}) : MAGW'(rs);
                q_next[i]   = {q_reg[s-1][i][QBITS-2:0], ge};
                nl_next[i]  = nl_reg[s-1][i] << 1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                r_reg[s]    <= r_next;
                q_reg[s]    <= q_next;
                d_reg[s]    <= d_reg[s-1];
                ov_reg[s]   <= ov_reg[s-1];
                neg_reg[s]  <= neg_reg[s-1];
                sing_reg[s] <= sing_reg[s-1];
            end
        end

        if (s < QBITS)
        begin : g_nl
            always_ff @(posedge clk)
            begin
                if (en[s])
                begin
                    nl_reg[s] <= nl_next;
                end
            end
        end
    end

    // last stage: round half away from zero on the magnitude
    logic [QBITS:0] qr_next [NE];

    always_comb
    begin
        logic rnd;
        for (int i = 0; i < NE; i++)
        begin
            rnd        = ({r_reg[QBITS][i], 1'b0} >= {1'b0, d_reg[QBITS]});
            qr_next[i] = {1'b0, q_reg[QBITS][i]} + {{QBITS{1'b0}}, rnd};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[NS-1])
        begin
            qr_reg         <= qr_next;
            ov_reg[NS-1]   <= ov_reg[NS-2];
            neg_reg[NS-1]  <= neg_reg[NS-2];
            sing_reg[NS-1] <= sing_reg[NS-2];
        end
    end

    always_comb
    begin
        dn_data.sing = sing_reg[NS-1];
        dn_data.neg  = neg_reg[NS-1];
        dn_data.ov   = ov_reg[NS-1];
        for (int i = 0; i < NE; i++)
        begin
            dn_data.qr[i] = qr_reg[i];
        end
    end

endmodule

@@ rtl/core/matrix3x3_inverse.sv @@
// 3x3 fixed-point matrix inverse, top level
// usage
//   matrix: request channel with nine signed entries in column-major order,
//     taken at a rising edge where matrix.valid and matrix.ready are both high
//   inverse: request channel with the invertible flag and nine inverse
//     entries, delivered when inverse.valid and inverse.ready are both high
//   cfg_wr_en / cfg_wr_data: write of singular_threshold, change it only while
//     no request is in flight
// throughput: one matrix per cycle while the output is not stalled, every
//   stage has its own valid bit
// pipeline: 7 cofactor/determinant stages, 35 divider stages (33 quotient
//   bits, one per stage, plus setup and rounding) and the output register
// stall: a stage moves on when empty or when the next stage moves, so holes
//   close up behind a stalled output and matrix.ready drops only once every
//   stage holds a request
// reset: clears all valid bits, the threshold returns to 1
// a matrix with |det| below threshold * 2^(2*FRAC_BITS), or det zero, comes
//   out with invertible low and all entries zero
// entries that overflow saturate to the signed 32-bit range
module matrix3x3_inverse
    import m3inv_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    m3inv_in_if.sink         matrix,
    m3inv_out_if.source      inverse,
    input  logic             cfg_wr_en,
    input  logic [THR_W-1:0] cfg_wr_data
);

    localparam int DEPTH = DET_STAGES + DIV_STAGES + 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    // threshold register
    logic [THR_W-1:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= THR_W'(1);
        end
        else if (cfg_wr_en)
        begin
            thr_reg <= cfg_wr_data;
        end
    end

    // determinant front end
    logic     det_valid, det_ready;
    det_res_t det_data;

    m3inv_det u_det (
        .clk      (clk),
        .rst_n    (rst_n),
        .matrix   (matrix),
        .dn_ready (det_ready),
        .dn_valid (det_valid),
        .dn_data  (det_data)
    );

    // divider back end
    logic     div_valid, div_ready;
    div_res_t div_data;

    m3inv_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .thr      (thr_reg),
        .up_valid (det_valid),
        .up_ready (det_ready),
        .up_data  (det_data),
        .dn_ready (div_ready),
        .dn_valid (div_valid),
        .dn_data  (div_data)
    );

    // output register: saturation, sign and singular blanking
    logic          ov_reg, ov_next;
    logic          inv_ok_reg;
    elem_t         inv_reg [NE], inv_next [NE];

    assign div_ready = !ov_reg || inverse.ready;

    always_comb
    begin
        logic [QBITS:0] lim;
        logic           sat;
        ov_next = div_ready ? div_valid : ov_reg;
        for (int i = 0; i < NE; i++)
        begin
            lim = div_data.neg[i] ? LIM_NEG : LIM_POS;
            sat = div_data.ov[i] || (div_data.qr[i] > lim);
            if (div_data.sing)
            begin
                inv_next[i] = '0;
            end
            else if (sat)
            begin
                inv_next[i] = div_data.neg[i] ? SAT_NEG : SAT_POS;
            end
            else if (div_data.neg[i])
            begin
                inv_next[i] = EW'(0) - div_data.qr[i][EW-1:0];
            end
            else
            begin
                inv_next[i] = div_data.qr[i][EW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ov_reg <= 1'b0;
        end
        else
        begin
            ov_reg <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (div_ready)
        begin
            inv_reg    <= inv_next;
            inv_ok_reg <= !div_data.sing;
        end
    end

    assign inverse.valid         = ov_reg;
    assign inverse.invertible    = inv_ok_reg;
    assign inverse.inv_col0_row0 = inv_reg[0];
    assign inverse.inv_col0_row1 = inv_reg[1];
    assign inverse.inv_col0_row2 = inv_reg[2];
    assign inverse.inv_col1_row0 = inv_reg[3];
    assign inverse.inv_col1_row1 = inv_reg[4];
    assign inverse.inv_col1_row2 = inv_reg[5];
    assign inverse.inv_col2_row0 = inv_reg[6];
    assign inverse.inv_col2_row1 = inv_reg[7];
    assign inverse.inv_col2_row2 = inv_reg[8];

    // requests in flight, for checking only
    logic [CNT_W-1:0] inflight_reg, inflight_next;
    logic             acc, dlv;

    assign acc = matrix.valid && matrix.ready;
    assign dlv = inverse.valid && inverse.ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (acc && !dlv)
        begin
            inflight_next = inflight_reg + CNT_W'(1);
        end
        else if (dlv && !acc)
        begin
            inflight_next = inflight_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inflight_reg <= '0;
        end
        else
        begin
            inflight_reg <= inflight_next;
        end
    end

    // input backs up only behind a stalled output
    a_stall_from_output: assert property (@(posedge clk) disable iff (!rst_n)
        !matrix.ready |-> (inverse.valid && !inverse.ready))
        else $error("input stalled while output free");

    // a singular result carries zero entries
    a_singular_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (inverse.valid && !inverse.invertible) |->
        (inverse.inv_col0_row0 == '0 && inverse.inv_col0_row1 == '0 &&
         inverse.inv_col0_row2 == '0 && inverse.inv_col1_row0 == '0 &&
         inverse.inv_col1_row1 == '0 && inverse.inv_col1_row2 == '0 &&
         inverse.inv_col2_row0 == '0 && inverse.inv_col2_row1 == '0 &&
         inverse.inv_col2_row2 == '0))
        else $error("singular result with nonzero entries");

    // never more requests inside than stages
    a_inflight_bound: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= CNT_W'(DEPTH))
        else $error("more requests in flight than stages");

    // no result without an accepted request
    a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
        inverse.valid |-> (inflight_reg != '0))
        else $error("result with no request in flight");

endmodule

@@ dv/matrix3x3_inverse_tb.sv @@
// self-checking testbench for the 3x3 fixed-point matrix inverse pipeline
`timescale 1ns / 1ps

module matrix3x3_inverse_tb
    import m3inv_pkg::*;
();

    localparam int LIMIT_CYCLES = 400000;
    localparam int DRAIN_CYCLES = 60;      // extra wait once nothing is outstanding
    localparam int FB           = FRAC_BITS_DEF;

    typedef struct {
        elem_t e [NE];                     // column-major, index col*3+row
    } matrix_t;

    typedef struct {
        logic        invertible;
        logic [31:0] v [NE];
    } inverse_t;

    // golden inverse: exact cofactors, determinant, rounded quotient, saturation
    function automatic inverse_t compute_inverse(matrix_t m, logic [THR_W-1:0] thr);
        inverse_t            r;
        logic signed [127:0] a [NE];
        logic signed [127:0] cof [NE];
        logic signed [127:0] det;
        logic [127:0]        mag, lim, ca, q;
        logic                neg;
        for (int i = 0; i < NE; i++)
            a[i] = {{96{m.e[i][EW-1]}}, m.e[i]};
        for (int i = 0; i < NE; i++)
            cof[i] = a[COF_IDX[i][0]] * a[COF_IDX[i][1]] - a[COF_IDX[i][2]] * a[COF_IDX[i][3]];
        det = a[0] * cof[0] + a[3] * cof[1] + a[6] * cof[2];
        mag = det[127] ? -det : det;
        lim = {97'b0, thr} << (2 * FB);
        r.invertible = 1'b1;
        for (int i = 0; i < NE; i++)
            r.v[i] = '0;
        // zero determinant is singular even with a zero threshold
        if (mag == 0 || mag < lim)
        begin
            r.invertible = 1'b0;
            return r;
        end
        for (int i = 0; i < NE; i++)
        begin
            neg = cof[i][127] ^ det[127];
            ca  = cof[i][127] ? -cof[i] : cof[i];
            // round half away from zero on the magnitude
            q   = (((ca << (2 * FB)) << 1) + mag) / (mag << 1);
            if (q == 0)
                r.v[i] = '0;
            else if (q > (neg ? 128'h8000_0000 : 128'h7FFF_FFFF))
                r.v[i] = neg ? SAT_NEG : SAT_POS;
            else
                r.v[i] = neg ? 32'(-q) : q[31:0];
        end
        return r;
    endfunction

    class inverse_scoreboard;
        inverse_t         pending [$];
        logic [THR_W-1:0] threshold = THR_W'(1);
        int               errors;
        int               accepted;
        int               checked;
        int               singular;
        int               saturated;

        task report(string msg);
            $display("ERROR: %s", msg);
            errors++;
        endtask

        function void note_matrix(matrix_t m);
            inverse_t x;
            x = compute_inverse(m, threshold);
            if (!x.invertible)
                singular++;
            for (int i = 0; i < NE; i++)
                if (x.invertible && (x.v[i] == SAT_POS || x.v[i] == SAT_NEG))
                    saturated++;
            pending.push_back(x);
            accepted++;
        endfunction

        task check_inverse(inverse_t got);
            inverse_t x;
            if (pending.size() == 0)
            begin
                report("inverse with no matrix outstanding");
                return;
            end
            x = pending.pop_front();
            if (got.invertible !== x.invertible)
                report($sformatf("result %0d invertible got %b exp %b",
                                 checked, got.invertible, x.invertible));
            for (int i = 0; i < NE; i++)
                if (got.v[i] !== x.v[i])
                    report($sformatf("result %0d inv_col%0d_row%0d got %h exp %h",
                                     checked, i / 3, i % 3, got.v[i], x.v[i]));
            checked++;
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic [THR_W-1:0] cfg_wr_data;

    m3inv_in_if  mat_if ();
    m3inv_out_if inv_if ();

    matrix3x3_inverse i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .matrix     (mat_if),
        .inverse    (inv_if),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    inverse_scoreboard sb = new();

    bit calm;          // no idling on either side in the last stretch
    int cycles;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random ready bursts, plus one long hold-off so the pipe fills
    initial
    begin
        inverse_t got;
        int       idle_left;
        bit       held;
        idle_left = 0;
        held      = 0;
        inv_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && inv_if.valid && inv_if.ready)
            begin
                got.invertible = inv_if.invertible;
                got.v[0] = inv_if.inv_col0_row0;
                got.v[1] = inv_if.inv_col0_row1;
                got.v[2] = inv_if.inv_col0_row2;
                got.v[3] = inv_if.inv_col1_row0;
                got.v[4] = inv_if.inv_col1_row1;
                got.v[5] = inv_if.inv_col1_row2;
                got.v[6] = inv_if.inv_col2_row0;
                got.v[7] = inv_if.inv_col2_row1;
                got.v[8] = inv_if.inv_col2_row2;
                sb.check_inverse(got);
            end
            // long stall once, while the sender keeps offering
            if (!held && sb.checked == 350)
            begin
                held      = 1;
                idle_left = 400;
            end
            if (!rst_n)
                inv_if.ready <= 1'b0;
            else if (idle_left > 0)
            begin
                idle_left--;
                inv_if.ready <= 1'b0;
            end
            else if (!calm && $urandom_range(0, 7) == 0)
            begin
                idle_left = $urandom_range(1, 16) - 1;
                inv_if.ready <= 1'b0;
            end
            else
                inv_if.ready <= 1'b1;
        end
    end

    task automatic drive_matrix(matrix_t m);
        mat_if.col0_row0 <= m.e[0];
        mat_if.col0_row1 <= m.e[1];
        mat_if.col0_row2 <= m.e[2];
        mat_if.col1_row0 <= m.e[3];
        mat_if.col1_row1 <= m.e[4];
        mat_if.col1_row2 <= m.e[5];
        mat_if.col2_row0 <= m.e[6];
        mat_if.col2_row1 <= m.e[7];
        mat_if.col2_row2 <= m.e[8];
    endtask

    // offer one matrix request and hold it until taken
    task automatic send_matrix(matrix_t m);
        drive_matrix(m);
        mat_if.valid <= 1'b1;
        do
            @(posedge clk);
        while (!mat_if.ready);
        sb.note_matrix(m);
    endtask

    task automatic idle_sender(int n);
        mat_if.valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic wait_drained();
        mat_if.valid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // threshold changes only with the pipe empty
    task automatic write_threshold(logic [THR_W-1:0] thr);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= thr;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        sb.threshold = thr;
    endtask

    function automatic matrix_t diag(int d0, int d1, int d2);
        matrix_t m;
        for (int i = 0; i < NE; i++)
            m.e[i] = '0;
        m.e[0] = d0;
        m.e[4] = d1;
        m.e[8] = d2;
        return m;
    endfunction

    function automatic matrix_t fill(int v);
        matrix_t m;
        for (int i = 0; i < NE; i++)
            m.e[i] = v;
        return m;
    endfunction

    function automatic int small_entry();
        return int'($urandom_range(0, 1 << 18)) - (1 << 17);
    endfunction

    // mix of well-conditioned, full-range, near-singular and tiny-diagonal matrices
    function automatic matrix_t random_matrix();
        matrix_t m;
        int      kind;
        int      k;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < NE; i++)
            m.e[i] = small_entry();
        if (kind < 4)
        begin
            m.e[0] += 32'sh0002_0000;
            m.e[4] += 32'sh0002_0000;
            m.e[8] += 32'sh0002_0000;
        end
        else if (kind < 6)
        begin
            for (int i = 0; i < NE; i++)
                m.e[i] = $urandom;
        end
        else if (kind < 8)
        begin
            // third column is a combination of the first two, plus a little noise
            k = $urandom_range(0, 3) - 1;
            for (int r = 0; r < 3; r++)
                m.e[6 + r] = m.e[r] + k * m.e[3 + r] + int'($urandom_range(0, 2)) - 1;
        end
        else
        begin
            // small entries push inverse values into saturation
            for (int i = 0; i < NE; i++)
                m.e[i] = int'($urandom_range(0, 64)) - 32;
            m.e[0] = $urandom_range(1, 300);
            m.e[4] = $urandom_range(1, 300);
            m.e[8] = $urandom_range(1, 300);
        end
        return m;
    endfunction

    task automatic random_phase(int n, int pause_at);
        for (int i = 0; i < n; i++)
        begin
            if (i == pause_at)
                wait_drained();
            else if (!calm && $urandom_range(0, 5) == 0)
                idle_sender($urandom_range(1, 16));
            send_matrix(random_matrix());
        end
    endtask

    initial
    begin
        matrix_t m;
        mat_if.valid <= 1'b0;
        drive_matrix(fill(0));
        cfg_wr_en    <= 1'b0;
        cfg_wr_data  <= '0;
        rst_n         = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part with the reset threshold
        send_matrix(diag(32'sh0001_0000, 32'sh0001_0000, 32'sh0001_0000));   // identity
        send_matrix(diag(-32'sh0001_0000, 32'sh0002_0000, 32'sh0000_8000));
        send_matrix(fill(0));                                               // zero matrix
        send_matrix(fill(32'sh7FFF_FFFF));                                  // rank one
        send_matrix(fill(32'sh8000_0000));
        send_matrix(diag(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
        send_matrix(diag(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000));
        send_matrix(diag(32'sh8000_0000, 32'sh7FFF_FFFF, -1));
        send_matrix(diag(1, 1, 1));                                         // det below threshold
        send_matrix(diag(32'sh0001_0000, 32'sh0001_0000, 1));               // det on threshold
        send_matrix(diag(32'sh0001_0000, 32'sh0000_FFFF, 1));               // just below
        send_matrix(diag(32'sh0001_0000, 32'sh0001_0000, -1));              // saturates negative
        m = diag(0, 0, 0);                                                  // permutation
        m.e[1] = 32'sh0001_0000;
        m.e[3] = 32'sh0001_0000;
        m.e[8] = -32'sh0003_0000;
        send_matrix(m);
        m = fill(-1);
        m.e[0] = 32'sh7FFF_FFFF;
        m.e[4] = 32'sh8000_0000;
        send_matrix(m);

        write_threshold('0);
        send_matrix(diag(1, 1, 1));                                         // tiny det, zero limit
        send_matrix(fill(0));                                               // zero det, zero limit
        random_phase(300, -1);

        write_threshold(31'h7FFF_FFFF);
        random_phase(150, -1);

        write_threshold(31'($urandom_range(1, 1 << 20)));
        random_phase(500, 260);

        write_threshold(1);
        random_phase(200, -1);
        calm = 1;
        random_phase(250, -1);

        wait_drained();
        $display("%0d matrices checked over five threshold settings",
                 sb.checked);
        $display("%0d singular, %0d clipped entries", sb.singular, sb.saturated);
        if (sb.errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/core/m3inv_pkg.sv
rtl/core/m3inv_if.sv
rtl/core/m3inv_det.sv
rtl/core/m3inv_div.sv
rtl/core/matrix3x3_inverse.sv
dv/matrix3x3_inverse_tb.sv
